FILE: src/tbl_pkg.sv
// Shared types, constants and pixel functions for the background line renderer.
// No dependencies; every other file of the block refers to this package by scoped names.
package tbl_pkg;

   localparam int VRAM_BYTES     = 8192;
   localparam int VRAM_ADDR_W    = $clog2(VRAM_BYTES);
   localparam int TILES_PER_LINE = 20;
   localparam int COL_W          = 5;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [VRAM_ADDR_W-1:0] MAP_BASE = VRAM_ADDR_W'(16'h1800);
   localparam logic [7:0]             OOR_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      MODE_WRITE  = 2'd0,
      MODE_READ   = 2'd1,
      MODE_RENDER = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_RENDER = 2'd2
   } cmd_op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_MAP,
      BK_LO,
      BK_HI,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  line;
   } req_type;

   typedef struct packed {
      logic [7:0]       read_data;
      logic [COL_W-1:0] tile_column;
      logic [15:0]      pixel_shades;
      logic [15:0]      pixel_codes;
      logic             last;
   } rsp_type;

   typedef struct packed {
      cmd_op_type             op;
      logic                   oor;
      logic [VRAM_ADDR_W-1:0] addr;
      logic [7:0]             data;
      logic [7:0]             line;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Leftmost pixel comes from bit 7 of each plane and lands in bits 1:0.
   function automatic logic [15:0] pixel_codes_of(input logic [7:0] lo, input logic [7:0] hi);
      logic [15:0] codes;
      codes = '0;
      for (int p = 0; p < 8; p++) begin
         codes[2*p +: 2] = {hi[7-p], lo[7-p]};
      end
      return codes;
   endfunction

   function automatic logic [15:0] pixel_shades_of(input logic [15:0] codes,
                                                   input logic [7:0]  palette);
      logic [15:0] shades;
      shades = '0;
      for (int p = 0; p < 8; p++) begin
         shades[2*p +: 2] = palette[{codes[2*p +: 2], 1'b0} +: 2];
      end
      return shades;
   endfunction

endpackage

FILE: src/tbl_front.sv
// Front end: takes request transfers and sorts them into queue commands.
// Depends on tbl_pkg.
module tbl_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tbl_pkg::req_type          req_data,
   input  tbl_pkg::queue_status_type q_status,
   output logic                      push,
   output tbl_pkg::cmd_type          push_cmd
);

   logic in_range;
   logic keep;

   assign in_range  = req_data.address < 16'(tbl_pkg::VRAM_BYTES);
   assign req_stall = q_status.full;

   always_comb begin
      keep          = 1'b0;
      push_cmd.op   = tbl_pkg::CMD_WRITE;
      push_cmd.oor  = ~in_range;
      push_cmd.addr = req_data.address[tbl_pkg::VRAM_ADDR_W-1:0];
      push_cmd.data = req_data.write_data;
      push_cmd.line = req_data.line;
      unique case (tbl_pkg::mode_type'(req_data.mode))
         tbl_pkg::MODE_WRITE: begin
            // drop writes beyond the store
            keep        = in_range;
            push_cmd.op = tbl_pkg::CMD_WRITE;
         end
         tbl_pkg::MODE_READ: begin
            keep        = 1'b1;
            push_cmd.op = tbl_pkg::CMD_READ;
         end
         tbl_pkg::MODE_RENDER: begin
            keep        = 1'b1;
            push_cmd.op = tbl_pkg::CMD_RENDER;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_valid & ~req_stall & keep;

endmodule

FILE: src/tbl_queue.sv
// Command queue between the front end and the back end.
// Depends on tbl_pkg.
module tbl_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tbl_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output tbl_pkg::cmd_type          head_cmd,
   output tbl_pkg::queue_status_type q_status
);

   tbl_pkg::cmd_type entry_ff [tbl_pkg::QUEUE_DEPTH];

   logic [tbl_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tbl_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tbl_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign q_status.full  = count_ff == tbl_pkg::QUEUE_CNT_W'(tbl_pkg::QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign do_push        = push & ~q_status.full;
   assign do_pop         = pop & ~q_status.empty;
   assign head_cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/tbl_back.sv
// Back end: video memory, render sequencer, palette register and result register.
// Depends on tbl_pkg.
module tbl_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tbl_pkg::cmd_type          head_cmd,
   input  tbl_pkg::queue_status_type q_status,
   output logic                      pop,
   input  logic                      csr_write_enable,
   input  logic [7:0]                csr_write_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tbl_pkg::rsp_type          rsp_data
);

   localparam logic [tbl_pkg::COL_W-1:0] LAST_COL = tbl_pkg::COL_W'(tbl_pkg::TILES_PER_LINE - 1);

   logic [7:0] vram_mem [tbl_pkg::VRAM_BYTES];
   logic [7:0] rdata_ff;

   tbl_pkg::back_state_type state_ff, state_in;

   logic [tbl_pkg::COL_W-1:0]       col_ff, col_in;
   logic [7:0]                      line_ff, line_in;
   logic [7:0]                      tile_ff, tile_in;
   logic [7:0]                      lo_ff, lo_in;
   logic                            oor_ff, oor_in;
   logic [7:0]                      palette_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   tbl_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic                            mem_we;
   logic                            mem_re;
   logic [tbl_pkg::VRAM_ADDR_W-1:0] mem_addr;
   logic                            out_free;
   logic [15:0]                     codes;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign codes     = tbl_pkg::pixel_codes_of(lo_ff, rdata_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      tile_in      = tile_ff;
      lo_in        = lo_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = head_cmd.addr;
      unique case (state_ff)
         tbl_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               case (head_cmd.op)
                  tbl_pkg::CMD_WRITE: begin
                     mem_we = 1'b1;
                  end
                  tbl_pkg::CMD_READ: begin
                     mem_re   = ~head_cmd.oor;
                     oor_in   = head_cmd.oor;
                     state_in = tbl_pkg::BK_READ;
                  end
                  tbl_pkg::CMD_RENDER: begin
                     line_in  = head_cmd.line;
                     col_in   = '0;
                     state_in = tbl_pkg::BK_MAP;
                  end
                  default: begin
                     state_in = tbl_pkg::BK_IDLE;
                  end
               endcase
            end
         end
         tbl_pkg::BK_READ: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.read_data    = oor_ff ? tbl_pkg::OOR_BYTE : rdata_ff;
               rsp_data_in.tile_column  = '0;
               rsp_data_in.pixel_shades = '0;
               rsp_data_in.pixel_codes  = '0;
               rsp_data_in.last         = 1'b1;
               state_in                 = tbl_pkg::BK_IDLE;
            end
         end
         tbl_pkg::BK_MAP: begin
            mem_re   = 1'b1;
            mem_addr = tbl_pkg::MAP_BASE
                     + tbl_pkg::VRAM_ADDR_W'({line_ff[7:3], col_ff});
            state_in = tbl_pkg::BK_LO;
         end
         tbl_pkg::BK_LO: begin
            // tile number arrives now; fetch the first bitplane byte
            tile_in  = rdata_ff;
            mem_re   = 1'b1;
            mem_addr = {1'b0, rdata_ff, line_ff[2:0], 1'b0};
            state_in = tbl_pkg::BK_HI;
         end
         tbl_pkg::BK_HI: begin
            lo_in    = rdata_ff;
            mem_re   = 1'b1;
            mem_addr = {1'b0, tile_ff, line_ff[2:0], 1'b1};
            state_in = tbl_pkg::BK_EMIT;
         end
         tbl_pkg::BK_EMIT: begin
            // hold the second plane byte in rdata_ff until the slot frees
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.read_data    = '0;
               rsp_data_in.tile_column  = col_ff;
               rsp_data_in.pixel_codes  = codes;
               rsp_data_in.pixel_shades = tbl_pkg::pixel_shades_of(codes, palette_ff);
               rsp_data_in.last         = col_ff == LAST_COL;
               if (col_ff == LAST_COL) begin
                  state_in = tbl_pkg::BK_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = tbl_pkg::BK_MAP;
               end
            end
         end
         default: begin
            state_in = tbl_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbl_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         palette_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            palette_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      line_ff     <= line_in;
      tile_ff     <= tile_in;
      lo_ff       <= lo_in;
      oor_ff      <= oor_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vram_mem[mem_addr] <= head_cmd.data;
      end
      if (mem_re) begin
         rdata_ff <= vram_mem[mem_addr];
      end
   end

endmodule

FILE: src/tile_background_line_renderer.sv
// Top level of the background line renderer: front end, command queue, back end.
// Depends on tbl_pkg, tbl_front, tbl_queue and tbl_back.
//
// Requests enter through a four-entry command queue, so up to four transfers are taken
// while the back end is busy. A write leaves the queue and is stored in video memory and
// gives no result; writes at 8192 or above and mode three are dropped at the front end.
// A read leaves the head of the queue; its byte is read into a register, then moved to the
// result register. A render gives twenty results, one per tile column; each column is a map
// read, two bitplane reads and the result, in that order. This sequence is set by the single
// read port of the 8 KiB video memory and the dependence of the bitplane address on the
// tile number. The result register stalls the sequencer only while it is full and stalled.
// The palette register is written through csr_write_enable and csr_write_data.
module tile_background_line_renderer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tbl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tbl_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data
);

   tbl_pkg::queue_status_type q_status;
   tbl_pkg::cmd_type          push_cmd;
   tbl_pkg::cmd_type          head_cmd;
   logic                      push;
   logic                      pop;

   tbl_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   tbl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   tbl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .q_status         (q_status),
      .pop              (pop),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

FILE: src/tbl_checker.sv
// Port-level checks on the background line renderer, bound to its top level.
// Depends on tbl_pkg and tile_background_line_renderer.
module tbl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input tbl_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tbl_pkg::rsp_type rsp_data,
   input logic             csr_write_enable,
   input logic [7:0]       csr_write_data
);

   localparam logic [tbl_pkg::COL_W-1:0] LAST_COL = tbl_pkg::COL_W'(tbl_pkg::TILES_PER_LINE - 1);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transfer changed");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.tile_column <= LAST_COL)
      else $error("tile column beyond the line");

   a_read_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_data != 8'd0 |->
         rsp_data.tile_column == '0 && rsp_data.pixel_codes == '0 &&
         rsp_data.pixel_shades == '0 && rsp_data.last)
      else $error("read result carries pixel fields");

   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tile_column != '0 |->
         rsp_data.last == (rsp_data.tile_column == LAST_COL))
      else $error("last flag does not match final column");

endmodule

bind tile_background_line_renderer tbl_checker u_tbl_checker (.*);

FILE: verif/tbl_line_checker.sv
`timescale 1ns / 1ps
// Result checker for tile_background_line_renderer: mirrors video memory and the palette,
// predicts every read byte and pixel group and compares them with result-channel transfers.
// Depends on tbl_pkg only.
module tbl_line_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  tbl_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  tbl_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data,
   output int unsigned      fail_count,
   output int unsigned      pending_count,
   output int unsigned      compared_count
);

   localparam int REPORT_LIMIT = 10;
   localparam int TILE_BYTES   = 16;
   localparam int MAP_ROW      = 32;

   logic [7:0]       vram_mirror [tbl_pkg::VRAM_BYTES];
   logic [7:0]       palette = '0;
   tbl_pkg::rsp_type due_results[$];

   function automatic logic [7:0] vram_byte(input int unsigned index);
      return vram_mirror[index % tbl_pkg::VRAM_BYTES];
   endfunction

   // One eight-pixel group of a line: map lookup, then the two bitplanes of that tile row.
   function automatic tbl_pkg::rsp_type column_pixels(input logic [7:0] line_no, input int col);
      tbl_pkg::rsp_type group;
      int unsigned      plane_addr;
      logic [7:0]       tile;
      logic [7:0]       plane0;
      logic [7:0]       plane1;
      logic [1:0]       code;
      tile       = vram_byte(int'(tbl_pkg::MAP_BASE) + (line_no / 8) * MAP_ROW + col);
      plane_addr = tile * TILE_BYTES + (line_no % 8) * 2;
      plane0     = vram_byte(plane_addr);
      plane1     = vram_byte(plane_addr + 1);
      group      = '0;
      group.tile_column = tbl_pkg::COL_W'(col);
      for (int px = 0; px < 8; px++) begin
         code = {plane1[7 - px], plane0[7 - px]};
         group.pixel_codes[2*px +: 2]  = code;
         group.pixel_shades[2*px +: 2] = palette[2*code +: 2];
      end
      group.last = (col == tbl_pkg::TILES_PER_LINE - 1);
      return group;
   endfunction

   task automatic note_failure(input string what, input tbl_pkg::rsp_type want,
                               input tbl_pkg::rsp_type got);
      if (fail_count < REPORT_LIMIT) begin
         $display("%0t: %s: expected rd=%02h col=%0d shades=%04h codes=%04h last=%0d",
                  $realtime, what, want.read_data, want.tile_column, want.pixel_shades,
                  want.pixel_codes, want.last);
         $display("%0t: %s: actual   rd=%02h col=%0d shades=%04h codes=%04h last=%0d",
                  $realtime, what, got.read_data, got.tile_column, got.pixel_shades,
                  got.pixel_codes, got.last);
      end
      fail_count <= fail_count + 1;
   endtask

   always @(posedge clock) begin
      tbl_pkg::rsp_type want;
      if (reset) begin
         palette = '0;
         due_results.delete();
         fail_count     <= 0;
         compared_count <= 0;
      end else begin
         // Results first: nothing accepted at this edge can already have its answer out.
         if (rsp_valid && !rsp_stall) begin
            compared_count <= compared_count + 1;
            if (due_results.size() == 0) begin
               note_failure("result transfer with nothing due", '0, rsp_data);
            end else begin
               want = due_results.pop_front();
               if (want.read_data !== rsp_data.read_data ||
                   want.tile_column !== rsp_data.tile_column ||
                   want.pixel_shades !== rsp_data.pixel_shades ||
                   want.pixel_codes !== rsp_data.pixel_codes ||
                   want.last !== rsp_data.last) begin
                  note_failure("result mismatch", want, rsp_data);
               end
            end
         end
         if (csr_write_enable) begin
            palette = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            case (req_data.mode)
               tbl_pkg::MODE_WRITE: begin
                  if (req_data.address < tbl_pkg::VRAM_BYTES) begin
                     vram_mirror[req_data.address] = req_data.write_data;
                  end
               end
               tbl_pkg::MODE_READ: begin
                  want = '0;
                  want.read_data = (req_data.address < tbl_pkg::VRAM_BYTES) ?
                                   vram_byte(req_data.address) : tbl_pkg::OOR_BYTE;
                  want.last = 1'b1;
                  due_results.push_back(want);
               end
               tbl_pkg::MODE_RENDER: begin
                  for (int col = 0; col < tbl_pkg::TILES_PER_LINE; col++) begin
                     due_results.push_back(column_pixels(req_data.line, col));
                  end
               end
               default: begin
                  // mode three is dropped by the block
               end
            endcase
         end
      end
      pending_count <= due_results.size();
   end

endmodule

FILE: verif/tile_background_line_renderer_tb.sv
`timescale 1ns / 1ps
// Testbench top for tile_background_line_renderer: clock, reset, stimulus and verdict.
// Depends on tbl_pkg, the block itself and tbl_line_checker.
module tile_background_line_renderer_tb;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 120;
   localparam int ITEM_TARGET   = 350;
   localparam int PHASES        = 4;
   localparam int TILE_BYTES    = 16;
   localparam int MAP_ROW       = 32;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   tbl_pkg::req_type req_data         = '0;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   tbl_pkg::rsp_type rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [7:0]       csr_write_data   = '0;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned compared_count;

   // What has been stored so far, so reads and renders only touch written bytes.
   logic [7:0] vram_shadow [tbl_pkg::VRAM_BYTES];
   bit         stored [tbl_pkg::VRAM_BYTES];
   int         stored_list[$];
   logic [7:0] tile_pool [8];

   int         burst_left  = 0;
   int         idle_cycles = 0;
   int         sent_items  = 0;
   int         n_writes    = 0;
   int         n_reads     = 0;
   int         n_renders   = 0;
   int         n_dropped   = 0;
   int         n_palettes  = 0;
   logic [1:0] stall_style = '0;
   logic [6:0] stall_run   = '0;

   tile_background_line_renderer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   tbl_line_checker line_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .compared_count   (compared_count)
   );

   always #10 clock = ~clock;

   // Receiver: switch between free-running, light, heavy and square-wave stalling.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_style <= 2'($urandom_range(0, 3));
         stall_run   <= 7'($urandom_range(16, 96));
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_style)
         2'd0:    rsp_stall <= 1'b0;
         2'd1:    rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2:    rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_run[2];
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("no transfer for %0d cycles, %0d results still due", IDLE_LIMIT, pending_count);
         $display("tile_background_line_renderer_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request and hold it until the transfer; gaps only between bursts.
   task automatic send(input tbl_pkg::req_type item, input bit counts);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (counts) sent_items++;
   endtask

   task automatic write_byte(input logic [15:0] addr, input logic [7:0] value);
      tbl_pkg::req_type item;
      item.mode       = tbl_pkg::MODE_WRITE;
      item.address    = addr;
      item.write_data = value;
      item.line       = 8'($urandom_range(0, 255));
      send(item, addr < tbl_pkg::VRAM_BYTES);
      if (addr < tbl_pkg::VRAM_BYTES) begin
         if (!stored[addr]) stored_list.push_back(addr);
         stored[addr]      = 1'b1;
         vram_shadow[addr] = value;
         n_writes++;
      end else begin
         n_dropped++;
      end
   endtask

   task automatic read_byte(input logic [15:0] addr);
      tbl_pkg::req_type item;
      item.mode       = tbl_pkg::MODE_READ;
      item.address    = addr;
      item.write_data = 8'($urandom_range(0, 255));
      item.line       = 8'($urandom_range(0, 255));
      send(item, 1'b1);
      n_reads++;
   endtask

   task automatic drop_item();
      tbl_pkg::req_type item;
      item.mode       = tbl_pkg::MODE_NONE;
      item.address    = 16'($urandom_range(0, 65535));
      item.write_data = 8'($urandom_range(0, 255));
      item.line       = 8'($urandom_range(0, 255));
      send(item, 1'b0);
      n_dropped++;
   endtask

   function automatic logic [7:0] pick_tile();
      return ($urandom_range(0, 3) != 0) ? tile_pool[$urandom_range(0, 7)]
                                         : 8'($urandom_range(0, 255));
   endfunction

   // Fill in any map entry or bitplane byte of the line not yet written, then render it.
   task automatic render_line(input logic [7:0] line_no);
      tbl_pkg::req_type item;
      int               map_addr;
      int               plane_addr;
      for (int col = 0; col < tbl_pkg::TILES_PER_LINE; col++) begin
         map_addr = int'(tbl_pkg::MAP_BASE) + (line_no / 8) * MAP_ROW + col;
         if (!stored[map_addr]) write_byte(16'(map_addr), pick_tile());
         plane_addr = vram_shadow[map_addr] * TILE_BYTES + (line_no % 8) * 2;
         for (int b = 0; b < 2; b++) begin
            if (!stored[plane_addr + b]) begin
               write_byte(16'(plane_addr + b), 8'($urandom_range(0, 255)));
            end
         end
      end
      item.mode       = tbl_pkg::MODE_RENDER;
      item.address    = 16'($urandom_range(0, 65535));
      item.write_data = 8'($urandom_range(0, 255));
      item.line       = line_no;
      send(item, 1'b1);
      n_renders++;
   endtask

   function automatic logic [7:0] pick_line();
      int roll;
      int row;
      roll = $urandom_range(0, 9);
      if (roll < 6) row = $urandom_range(0, 3);
      else if (roll < 8) row = $urandom_range(28, 31);
      else row = $urandom_range(0, 31);
      return 8'(row * 8 + $urandom_range(0, 7));
   endfunction

   task automatic random_item();
      int choice;
      choice = $urandom_range(0, 99);
      if (choice < 30) begin
         if ($urandom_range(0, 1) == 1) begin
            write_byte(16'(int'(tbl_pkg::MAP_BASE) + $urandom_range(0, 31) * MAP_ROW +
                           $urandom_range(0, 31)), pick_tile());
         end else begin
            write_byte(16'($urandom_range(0, tbl_pkg::VRAM_BYTES - 1)),
                       8'($urandom_range(0, 255)));
         end
      end else if (choice < 36) begin
         write_byte(16'($urandom_range(tbl_pkg::VRAM_BYTES, 65535)), 8'($urandom_range(0, 255)));
      end else if (choice < 40) begin
         drop_item();
      end else if (choice < 58 && stored_list.size() > 0) begin
         read_byte(16'(stored_list[$urandom_range(0, stored_list.size() - 1)]));
      end else if (choice < 62) begin
         read_byte(16'($urandom_range(tbl_pkg::VRAM_BYTES, 65535)));
      end else begin
         render_line(pick_line());
      end
   endtask

   // Hold off the sender until every due result is in and the back end has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_palette(input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      n_palettes++;
   endtask

   initial begin
      int random_base;
      tile_pool[0] = 8'h00;
      tile_pool[1] = 8'hFF;
      for (int i = 2; i < 8; i++) tile_pool[i] = 8'($urandom_range(0, 255));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_palette(8'hE4);

      // Address extremes, out-of-range writes that must not alias, out-of-range reads.
      write_byte(16'h0000, 8'h00);
      write_byte(16'h1FFF, 8'hFF);
      read_byte(16'h0000);
      read_byte(16'h1FFF);
      write_byte(16'h2000, 8'h5A);
      write_byte(16'hFFFF, 8'h00);
      read_byte(16'h1FFF);
      read_byte(16'h2000);
      read_byte(16'hFFFF);
      drop_item();
      render_line(8'd255);

      random_base = sent_items;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0:       set_palette(8'h00);
            1:       set_palette(8'hFF);
            2:       set_palette(8'($urandom_range(0, 255)));
            default: set_palette(8'h1B);
         endcase
         while (sent_items < random_base + (ITEM_TARGET * (phase + 1)) / PHASES) random_item();
      end
      settle();

      $display("Covered %0d writes, %0d reads, %0d line renders and %0d dropped requests",
               n_writes, n_reads, n_renders, n_dropped);
      $display("under %0d palette settings; %0d results compared, %0d failures.",
               n_palettes, compared_count, fail_count);
      if (fail_count == 0) begin
         $display("tile_background_line_renderer_tb: PASS");
      end else begin
         $display("tile_background_line_renderer_tb: FAIL");
      end
      $finish;
   end

endmodule
